[rtl/acrc_pkg.sv]
// acrc_pkg: shared types and constants for the associative cache replacement classifier
// no dependencies; used by every module under rtl
`default_nettype none

package acrc_pkg;

	localparam int ADDR_IN_W  = 16;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'd1;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	typedef struct packed {
		logic busy;
		logic seen;
	} seen_status_t;

endpackage

`default_nettype wire

[rtl/acrc_seen_tracker.sv]
// acrc_seen_tracker: seen-address bitmap memory with post-reset clearing sweep and
// write-to-read forwarding; depends on acrc_pkg
`default_nettype none

module acrc_seen_tracker #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_BITS-1:0] rd_tag,
	input  wire logic [ADDR_BITS-1:0] cur_tag,
	input  wire logic                 set_en,
	output acrc_pkg::seen_status_t    status
);

	localparam int BIT_BITS = (ADDR_BITS > 8) ? 5 : 3;
	localparam int ROW_W    = 1 << BIT_BITS;
	localparam int ROW_BITS = ADDR_BITS - BIT_BITS;
	localparam int NUM_ROWS = 1 << ROW_BITS;

	logic [ROW_W-1:0]    mem [NUM_ROWS];
	logic [ROW_W-1:0]    rd_data_s1;
	logic                fwd_s1;
	logic [ROW_W-1:0]    fwd_data_s1;
	logic                clr_busy_q;
	logic [ROW_BITS-1:0] clr_row_q;

	logic [ROW_BITS-1:0] rd_row;
	logic [ROW_BITS-1:0] cur_row;
	logic [BIT_BITS-1:0] cur_bit;
	logic [ROW_W-1:0]    row_eff;
	logic [ROW_W-1:0]    wr_data;

	assign rd_row  = rd_tag[ADDR_BITS-1:BIT_BITS];
	assign cur_row = cur_tag[ADDR_BITS-1:BIT_BITS];
	assign cur_bit = cur_tag[BIT_BITS-1:0];
	assign row_eff = fwd_s1 ? fwd_data_s1 : rd_data_s1;
	assign wr_data = row_eff | (ROW_W'(1) << cur_bit);

	assign status.busy = clr_busy_q;
	assign status.seen = row_eff[cur_bit];

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_row_q] <= '0;
		end else if (set_en) begin
			mem[cur_row] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1  <= mem[rd_row];
			fwd_data_s1 <= wr_data;
		end
	end

	// a row written in the same cycle as it is read returns stale data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_s1 <= set_en && (cur_row == rd_row);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			if (&clr_row_q) begin
				clr_busy_q <= 1'b0;
			end
			clr_row_q <= clr_row_q + ROW_BITS'(1);
		end
	end

endmodule

`default_nettype wire

[rtl/acrc_tag_list.sv]
// acrc_tag_list: ordered tag list with parallel compare, one-step shift update,
// capacity and policy registers; depends on acrc_pkg
`default_nettype none

module acrc_tag_list #(
	parameter int MAX_WAYS  = 16,
	parameter int ADDR_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [acrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [acrc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [ADDR_BITS-1:0]            tag,
	input  wire logic                            upd,
	output logic                                 hit
);

	localparam int CAP_W = $clog2(MAX_WAYS + 1);

	logic [ADDR_BITS-1:0]           tag_q [MAX_WAYS];
	logic [MAX_WAYS-1:0]            valid_q;
	logic [acrc_pkg::CFG_DATA_W-1:0] ways_q;
	logic                           policy_q;

	logic [CAP_W-1:0]    cap;
	logic [CAP_W-1:0]    new_cap;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] match_ahead;
	logic [MAX_WAYS-1:0] shift;
	logic                ld_front;

	function automatic logic [CAP_W-1:0] eff_cap(input logic [acrc_pkg::CFG_DATA_W-1:0] w);
		int unsigned v;
		v = 32'(w);
		if (v == 0) begin
			v = 1;
		end else if (v > MAX_WAYS) begin
			v = MAX_WAYS;
		end
		return CAP_W'(v);
	endfunction

	assign cap     = eff_cap(ways_q);
	assign new_cap = eff_cap(cfg_data);

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			match[i]  = valid_q[i] && (tag_q[i] == tag);
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			match_ahead[i] = |(match & ({MAX_WAYS{1'b1}} >> (MAX_WAYS - i)));
		end
	end

	assign hit      = |match;
	assign ld_front = upd && (!hit || (policy_q == acrc_pkg::POLICY_LRU));

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (hit) begin
				shift[i] = upd && (policy_q == acrc_pkg::POLICY_LRU) && !match_ahead[i];
			end else begin
				shift[i] = upd && (CAP_W'(i) < cap);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_front) begin
			tag_q[0] <= tag;
		end
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (shift[i]) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ways_q   <= acrc_pkg::CFG_DATA_W'(16);
			policy_q <= acrc_pkg::POLICY_LRU;
		end else if (cfg_we) begin
			if (cfg_index == acrc_pkg::CFG_WAYS_IN_USE) begin
				ways_q <= cfg_data;
				for (int i = 0; i < MAX_WAYS; i++) begin
					if (CAP_W'(i) >= new_cap) begin
						valid_q[i] <= 1'b0;
					end
				end
			end else begin
				policy_q <= cfg_data[0];
			end
		end else if (upd && !hit) begin
			valid_q[0] <= 1'b1;
			for (int i = 1; i < MAX_WAYS; i++) begin
				if (shift[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/assoc_cache_replacement_classifier_core.sv]
// assoc_cache_replacement_classifier_core: top level of the cache replacement classifier
// depends on acrc_pkg, acrc_tag_list and acrc_seen_tracker
// an access is held in tag_s1 and its result registered into the output once that is free
// throughput: one access per cycle when not stalled; tag list compare and shift are one stage
// reset: the seen bitmap clearing sweep runs over 2^(ADDR_BITS-5) rows (2^(ADDR_BITS-3) when
// ADDR_BITS <= 8), 2048 rows at defaults, with s_axis_tready low; config writes taken
`default_nettype none

module assoc_cache_replacement_classifier_core #(
	parameter int MAX_WAYS  = 16,
	parameter int ADDR_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [acrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [acrc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// access_address
	input  wire logic [15:0]                     s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// access_count, compulsory_count, capacity_count
	output logic [95:0]                          m_axis_tdata,
	// hit, compulsory_miss, capacity_miss
	output logic [2:0]                           m_axis_tuser
);

	logic                        valid_s1;
	logic [ADDR_BITS-1:0]        tag_s1;
	logic                        m_valid_q;
	logic [2:0]                  flags_q;
	logic [acrc_pkg::CNT_W-1:0]  acc_cnt_q;
	logic [acrc_pkg::CNT_W-1:0]  comp_cnt_q;
	logic [acrc_pkg::CNT_W-1:0]  cap_cnt_q;

	logic                   in_accept;
	logic                   advance;
	logic [ADDR_BITS-1:0]   in_tag;
	logic                   hit;
	logic                   comp_miss;
	logic                   cap_miss;
	acrc_pkg::seen_status_t seen_st;

	assign in_tag        = ADDR_BITS'(s_axis_tdata[acrc_pkg::ADDR_IN_W-1:0]);
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !seen_st.busy && (!valid_s1 || advance);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign comp_miss = !hit && !seen_st.seen;
	assign cap_miss  = !hit && seen_st.seen;

	acrc_tag_list #(
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_tag_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tag       (tag_s1),
		.upd       (advance),
		.hit       (hit)
	);

	acrc_seen_tracker #(
		.ADDR_BITS (ADDR_BITS)
	) u_seen_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_tag  (in_tag),
		.cur_tag (tag_s1),
		.set_en  (advance && !hit),
		.status  (seen_st)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tag_s1 <= in_tag;
		end
		if (advance) begin
			flags_q <= {cap_miss, comp_miss, hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_valid_q  <= 1'b0;
			acc_cnt_q  <= '0;
			comp_cnt_q <= '0;
			cap_cnt_q  <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			// counters saturate at all ones
			if (advance) begin
				if (!(&acc_cnt_q)) begin
					acc_cnt_q <= acc_cnt_q + acrc_pkg::CNT_W'(1);
				end
				if (comp_miss && !(&comp_cnt_q)) begin
					comp_cnt_q <= comp_cnt_q + acrc_pkg::CNT_W'(1);
				end
				if (cap_miss && !(&cap_cnt_q)) begin
					cap_cnt_q <= cap_cnt_q + acrc_pkg::CNT_W'(1);
				end
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {cap_cnt_q, comp_cnt_q, acc_cnt_q};
	assign m_axis_tuser  = flags_q;

endmodule

`default_nettype wire

[bench/assoc_cache_replacement_classifier_core_tb.sv]
// assoc_cache_replacement_classifier_core_tb: self-checking bench for the cache classifier
// drives access transactions, predicts hit / compulsory / capacity outcomes and saturating counts
// depends on acrc_pkg and assoc_cache_replacement_classifier_core
`timescale 1ns / 100ps
`default_nettype none

module assoc_cache_replacement_classifier_core_tb;

	localparam int N_WAYS    = 16;
	localparam int TIMEOUT   = 400000;

	typedef struct packed {
		logic        hit;
		logic        comp_miss;
		logic        cap_miss;
		logic [31:0] n_access;
		logic [31:0] n_comp;
		logic [31:0] n_cap;
	} access_outcome_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [acrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [acrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	// access_address
	logic [15:0]                     s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// access_count, compulsory_count, capacity_count
	logic [95:0]                     m_axis_tdata;
	// hit, compulsory_miss, capacity_miss
	logic [2:0]                      m_axis_tuser;

	assoc_cache_replacement_classifier_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// cache shadow state
	logic [15:0] way_tag [N_WAYS];
	logic        way_vld [N_WAYS];
	bit          seen_map [65536];
	logic [31:0] tot_access, tot_comp, tot_cap;
	logic [4:0]  ways_setting;
	logic        policy_setting;

	logic [15:0]     addr_backlog [$];
	access_outcome_t expected_outcomes [$];
	int              queued_cnt, accepted_cnt, checked_cnt, error_cnt, cycle_cnt;
	int              hit_cnt, settings_cnt;
	int              src_idle_pct, dst_idle_pct;
	logic            src_took = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int active_ways();
		if (ways_setting == 0)
			return 1;
		if (ways_setting > N_WAYS)
			return N_WAYS;
		return int'(ways_setting);
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic access_outcome_t lookup_and_update(input logic [15:0] addr);
		access_outcome_t r;
		int cap, used, pos;
		cap = active_ways();
		used = 0;
		pos = -1;
		r = '0;
		for (int i = 0; i < cap; i++) begin
			if (!way_vld[i])
				break;
			used++;
			if (pos < 0 && way_tag[i] == addr)
				pos = i;
		end
		tot_access = sat_inc(tot_access);
		if (pos >= 0) begin
			r.hit = 1'b1;
			hit_cnt++;
			if (policy_setting == acrc_pkg::POLICY_LRU) begin
				for (int i = pos; i > 0; i--)
					way_tag[i] = way_tag[i-1];
				way_tag[0] = addr;
			end
		end else begin
			if (used >= cap)
				used = cap - 1;
			for (int i = used; i > 0; i--)
				way_tag[i] = way_tag[i-1];
			way_tag[0] = addr;
			for (int i = 0; i <= used; i++)
				way_vld[i] = 1'b1;
			if (seen_map[addr]) begin
				r.cap_miss = 1'b1;
				tot_cap = sat_inc(tot_cap);
			end else begin
				r.comp_miss = 1'b1;
				tot_comp = sat_inc(tot_comp);
				seen_map[addr] = 1'b1;
			end
		end
		r.n_access = tot_access;
		r.n_comp = tot_comp;
		r.n_cap = tot_cap;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			error_cnt++;
		end
	endtask

	// source driver and sink ready pacing
	always @(negedge clk) begin
		if (!(s_axis_tvalid && !src_took)) begin
			if (addr_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_axis_tdata <= addr_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		access_outcome_t exp_o;
		cycle_cnt++;
		if (cycle_cnt > TIMEOUT) begin
			$display("assoc_cache_replacement_classifier_core verification failed");
			$finish;
		end
		src_took = arst_n && s_axis_tvalid && s_axis_tready;
		if (src_took) begin
			expected_outcomes.insert(expected_outcomes.size(), lookup_and_update(s_axis_tdata));
			accepted_cnt++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_outcomes.size() == 0) begin
				$error("result transaction with no access pending");
				error_cnt++;
			end else begin
				exp_o = expected_outcomes.pop_front();
				compare_field("hit", 32'(exp_o.hit), 32'(m_axis_tuser[0]));
				compare_field("compulsory_miss", 32'(exp_o.comp_miss), 32'(m_axis_tuser[1]));
				compare_field("capacity_miss", 32'(exp_o.cap_miss), 32'(m_axis_tuser[2]));
				compare_field("access_count", exp_o.n_access, m_axis_tdata[31:0]);
				compare_field("compulsory_count", exp_o.n_comp, m_axis_tdata[63:32]);
				compare_field("capacity_count", exp_o.n_cap, m_axis_tdata[95:64]);
				checked_cnt++;
			end
		end
	end

	task automatic push_addr(input logic [15:0] a);
		addr_backlog.insert(addr_backlog.size(), a);
		queued_cnt++;
	endtask

	task automatic settle();
		while (accepted_cnt != queued_cnt || expected_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [acrc_pkg::CFG_IDX_W-1:0] idx,
			input logic [acrc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == acrc_pkg::CFG_WAYS_IN_USE) begin
			ways_setting = val;
			for (int i = active_ways(); i < N_WAYS; i++)
				way_vld[i] = 1'b0;
		end else begin
			policy_setting = val[0];
		end
		settings_cnt++;
	endtask

	task automatic set_pace(input int src_pct, input int dst_pct);
		@(posedge clk);
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
	endtask

	// working set of 2 * active ways + 3 addresses, with some wide-range and edge addresses
	task automatic push_random(input int n, input int base, input int span);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 82)
				push_addr(16'(base + $urandom_range(span)));
			else if (r < 94)
				push_addr(16'($urandom));
			else
				push_addr($urandom_range(1) ? 16'hFFFF : 16'h0000);
		end
	endtask

	task automatic run_phase(input logic [4:0] ways, input logic pol, input int src_pct,
			input int dst_pct, input int n);
		int span, base;
		cfg_write(acrc_pkg::CFG_WAYS_IN_USE, ways);
		cfg_write(acrc_pkg::CFG_POLICY_MODE, {4'd0, pol});
		set_pace(src_pct, dst_pct);
		span = 2 * active_ways() + 2;
		base = int'($urandom_range(65535 - span));
		push_random(n / 2, base, span);
		// hold off until the pipe is empty, then continue with the same setting
		settle();
		push_random(n - n / 2, base, span);
		settle();
	endtask

	initial begin
		for (int i = 0; i < N_WAYS; i++) begin
			way_tag[i] = '0;
			way_vld[i] = 1'b0;
		end
		tot_access = '0;
		tot_comp = '0;
		tot_cap = '0;
		ways_setting = 5'd16;
		policy_setting = acrc_pkg::POLICY_LRU;
		queued_cnt = 0;
		accepted_cnt = 0;
		checked_cnt = 0;
		error_cnt = 0;
		cycle_cnt = 0;
		hit_cnt = 0;
		settings_cnt = 0;
		src_idle_pct = 23;
		dst_idle_pct = 54;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: extremes and lru hits
		push_addr(16'h0000);
		push_addr(16'hFFFF);
		push_addr(16'h0000);
		push_addr(16'h5555);
		push_addr(16'hAAAA);
		push_addr(16'hFFFF);
		settle();

		// zero ways acts as one way, shrinking drops entries
		cfg_write(acrc_pkg::CFG_WAYS_IN_USE, 5'd0);
		push_addr(16'h0000);
		push_addr(16'h0000);
		push_addr(16'h1234);
		push_addr(16'h0000);
		settle();

		// oversized way count with fifo order
		cfg_write(acrc_pkg::CFG_WAYS_IN_USE, 5'd31);
		cfg_write(acrc_pkg::CFG_POLICY_MODE, {4'd0, acrc_pkg::POLICY_FIFO});
		push_addr(16'h0001);
		push_addr(16'h0002);
		push_addr(16'h0001);
		push_addr(16'h0003);
		push_addr(16'h1234);
		settle();

		// shrink to two ways under fifo, then back to lru keeping the list
		cfg_write(acrc_pkg::CFG_WAYS_IN_USE, 5'd2);
		push_addr(16'h0002);
		push_addr(16'h0001);
		settle();
		cfg_write(acrc_pkg::CFG_POLICY_MODE, {4'd0, acrc_pkg::POLICY_LRU});
		push_addr(16'h0001);
		push_addr(16'h0003);
		settle();

		run_phase(5'd16, acrc_pkg::POLICY_LRU, 23, 54, 200);
		run_phase(5'd1, acrc_pkg::POLICY_FIFO, 23, 54, 100);
		run_phase(5'd4, acrc_pkg::POLICY_LRU, 54, 23, 200);
		run_phase(5'd17, acrc_pkg::POLICY_FIFO, 54, 23, 150);
		run_phase(5'd8, acrc_pkg::POLICY_FIFO, 0, 0, 200);
		run_phase(5'd0, acrc_pkg::POLICY_LRU, 0, 0, 50);
		run_phase(5'd31, acrc_pkg::POLICY_LRU, 0, 0, 150);
		run_phase(5'($urandom_range(2, 15)), 1'($urandom), 0, 0, 100);

		repeat (16) @(negedge clk);
		$display("ran %0d accesses over %0d register writes: %0d hits, %0d compulsory, %0d capacity",
			checked_cnt, settings_cnt, hit_cnt, tot_comp, tot_cap);
		if (error_cnt == 0)
			$display("assoc_cache_replacement_classifier_core verification clean");
		else
			$display("assoc_cache_replacement_classifier_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire
